// ===== rtl/core/sgp_pkg.sv =====
// Shared types and constants of the streaming graph partitioner.
package sgp_pkg;

    localparam int MAX_PARTS    = 16;
    localparam int PART_W       = $clog2(MAX_PARTS);
    localparam int PCNT_W       = PART_W + 1;
    localparam int MAX_VERTICES = 65536;
    localparam int VID_W        = 16;
    localparam int TAB_AW       = $clog2(MAX_VERTICES);
    localparam int TAB_W        = PART_W + 1;
    localparam int HIT_W        = 16;
    localparam int SIZE_W       = 17;
    localparam int N_W          = SIZE_W + 1;
    localparam int ROOT_W       = 25;
    localparam int PROD_W       = N_W + ROOT_W;
    localparam int DIFF_W       = 27;
    localparam int ALPHA_W      = 32;
    localparam int PEN_W        = ALPHA_W + DIFF_W - 16;
    localparam int SCORE_W      = PEN_W + 2;

    localparam logic [HIT_W-1:0]  HIT_MAX  = '1;
    localparam logic [SIZE_W-1:0] SIZE_MAX = '1;

    localparam logic [1:0] REG_PART_COUNT = 2'd0;
    localparam logic [1:0] REG_CAPACITY   = 2'd1;
    localparam logic [1:0] REG_ALPHA      = 2'd2;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOK,
        S_CHECK,
        S_ROOTA,
        S_MULA,
        S_ROOTB,
        S_MULB,
        S_DIFF,
        S_PEN,
        S_SCORE,
        S_WRITE
    } t_state;

endpackage

// ===== rtl/core/streaming_graph_partitioner_top.sv =====
// Top level of the streaming graph partitioner.
// After reset the block clears its vertex table, one entry a cycle, all 65536 entries, and
// accepts no item meanwhile. Neighbor items are then taken one per cycle while the block is
// idle; each looks up the vertex table (registered RAM read) and, for a valid neighbor that
// is already placed, counts a hit for the neighbor's part. The item marked last starts a scan
// over the active parts, after the lookup of that item: an eligible part costs two square
// roots plus start, multiply, subtract and compare steps, an ineligible part only a capacity
// check. The write-back waits for a free output register; no item is taken until it is done.
// The result waits in an output register while neighbor items keep flowing.
module streaming_graph_partitioner_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // vertex_id, neighbor_id
    input  logic        i_s_tuser,   // neighbor_valid
    input  logic        i_s_tlast,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // placed_vertex, partition, any_eligible, zero pad
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int PW = sgp_pkg::PART_W;

    sgp_pkg::t_state r_state, n_state;

    logic [sgp_pkg::PCNT_W-1:0]  r_part_count;
    logic [sgp_pkg::SIZE_W-1:0]  r_capacity;
    logic [sgp_pkg::ALPHA_W-1:0] r_alpha;

    logic [sgp_pkg::HIT_W-1:0]  r_hits  [sgp_pkg::MAX_PARTS];
    logic [sgp_pkg::SIZE_W-1:0] r_sizes [sgp_pkg::MAX_PARTS];

    logic [sgp_pkg::TAB_AW-1:0] r_clr;
    logic                       r_p1_valid;
    logic                       r_p1_nv;
    logic [sgp_pkg::VID_W-1:0]  r_vid;
    logic [PW-1:0]              r_idx;
    logic [PW-1:0]              r_best;
    logic                       r_found;
    logic signed [sgp_pkg::SCORE_W-1:0] r_best_score;
    logic [sgp_pkg::PROD_W-1:0] r_pa, r_pb;
    logic [sgp_pkg::DIFF_W-1:0] r_diff;
    logic [sgp_pkg::PEN_W-1:0]  r_pen;
    logic                       r_out_valid;
    logic [23:0]                r_out_data;

    logic                       ram_we;
    logic [sgp_pkg::TAB_AW-1:0] ram_addr;
    logic [sgp_pkg::TAB_W-1:0]  ram_wdata, ram_rdata;
    logic                       sq_start, sq_done;
    logic [sgp_pkg::N_W-1:0]    sq_n;
    logic [sgp_pkg::ROOT_W-1:0] sq_root;

    logic                       s_acc;
    logic                       cfg_wr;
    logic [sgp_pkg::PCNT_W-1:0] parts;
    logic [PW-1:0]              hit_addr, size_addr;
    logic [sgp_pkg::HIT_W-1:0]  hit_rd;
    logic [sgp_pkg::SIZE_W-1:0] size_rd;
    logic                       hit_inc;
    logic                       last_idx;
    logic                       out_free;
    logic signed [sgp_pkg::SCORE_W-1:0] score;
    logic [sgp_pkg::ALPHA_W+sgp_pkg::DIFF_W-1:0] pen_full;

    assign pready     = 1'b1;
    assign o_s_tready = (r_state == sgp_pkg::S_IDLE);
    assign s_acc      = i_s_tvalid && o_s_tready;
    assign cfg_wr     = psel && penable && pwrite && pready;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign out_free   = !r_out_valid || i_m_tready;

    always_comb begin
        parts = r_part_count;
        if (r_part_count == '0) begin
            parts = sgp_pkg::PCNT_W'(1);
        end else if (r_part_count > sgp_pkg::PCNT_W'(sgp_pkg::MAX_PARTS)) begin
            parts = sgp_pkg::PCNT_W'(sgp_pkg::MAX_PARTS);
        end
    end

    assign last_idx  = ({1'b0, r_idx} == parts - 1'b1);
    assign hit_inc   = r_p1_valid && r_p1_nv && ram_rdata[PW];
    assign hit_addr  = (r_state == sgp_pkg::S_SCORE) ? r_idx : ram_rdata[PW-1:0];
    assign size_addr = (r_state == sgp_pkg::S_WRITE) ? r_best : r_idx;
    assign hit_rd    = r_hits[hit_addr];
    assign size_rd   = r_sizes[size_addr];
    assign pen_full  = (sgp_pkg::ALPHA_W+sgp_pkg::DIFF_W)'(r_alpha)
                     * (sgp_pkg::ALPHA_W+sgp_pkg::DIFF_W)'(r_diff);
    assign score     = $signed({2'b00, {(sgp_pkg::PEN_W-sgp_pkg::HIT_W-16){1'b0}}, hit_rd, 16'd0})
                     - $signed({2'b00, r_pen});

    always_comb begin
        unique case (paddr[3:2])
            sgp_pkg::REG_PART_COUNT: prdata = {27'd0, r_part_count};
            sgp_pkg::REG_CAPACITY:   prdata = {15'd0, r_capacity};
            sgp_pkg::REG_ALPHA:      prdata = r_alpha;
            default:                 prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_part_count <= sgp_pkg::PCNT_W'(16);
            r_capacity   <= sgp_pkg::SIZE_W'(65536);
            r_alpha      <= sgp_pkg::ALPHA_W'(65536);
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                sgp_pkg::REG_PART_COUNT: r_part_count <= pwdata[sgp_pkg::PCNT_W-1:0];
                sgp_pkg::REG_CAPACITY:   r_capacity   <= pwdata[sgp_pkg::SIZE_W-1:0];
                sgp_pkg::REG_ALPHA:      r_alpha      <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_addr  = i_s_tdata[31:16];
        ram_wdata = '0;
        if (r_state == sgp_pkg::S_CLEAR) begin
            ram_we   = 1'b1;
            ram_addr = r_clr;
        end else if (r_state == sgp_pkg::S_WRITE) begin
            ram_we    = out_free;
            ram_addr  = r_vid;
            ram_wdata = {1'b1, r_best};
        end
    end

    sgp_ram #(
        .WIDTH (sgp_pkg::TAB_W),
        .DEPTH (sgp_pkg::MAX_VERTICES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    sgp_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_n     (sq_n),
        .o_done  (sq_done),
        .o_root  (sq_root)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sgp_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state  = r_state;
        sq_start = 1'b0;
        sq_n     = {1'b0, size_rd};
        unique case (r_state)
            sgp_pkg::S_CLEAR: begin
                if (r_clr == sgp_pkg::TAB_AW'(sgp_pkg::MAX_VERTICES - 1)) begin
                    n_state = sgp_pkg::S_IDLE;
                end
            end
            sgp_pkg::S_IDLE: begin
                if (s_acc && i_s_tlast) n_state = sgp_pkg::S_LOOK;
            end
            sgp_pkg::S_LOOK: n_state = sgp_pkg::S_CHECK;
            sgp_pkg::S_CHECK: begin
                if (size_rd > r_capacity) begin
                    n_state = last_idx ? sgp_pkg::S_WRITE : sgp_pkg::S_CHECK;
                end else begin
                    sq_start = 1'b1;
                    n_state  = sgp_pkg::S_ROOTA;
                end
            end
            sgp_pkg::S_ROOTA: begin
                if (sq_done) n_state = sgp_pkg::S_MULA;
            end
            sgp_pkg::S_MULA: begin
                sq_start = 1'b1;
                sq_n     = {1'b0, size_rd} + 1'b1;
                n_state  = sgp_pkg::S_ROOTB;
            end
            sgp_pkg::S_ROOTB: begin
                if (sq_done) n_state = sgp_pkg::S_MULB;
            end
            sgp_pkg::S_MULB:  n_state = sgp_pkg::S_DIFF;
            sgp_pkg::S_DIFF:  n_state = sgp_pkg::S_PEN;
            sgp_pkg::S_PEN:   n_state = sgp_pkg::S_SCORE;
            sgp_pkg::S_SCORE: n_state = last_idx ? sgp_pkg::S_WRITE : sgp_pkg::S_CHECK;
            sgp_pkg::S_WRITE: begin
                if (out_free) n_state = sgp_pkg::S_IDLE;
            end
            default: n_state = sgp_pkg::S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr       <= '0;
            r_p1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_idx       <= '0;
            r_found     <= 1'b0;
            r_best      <= '0;
            for (int i = 0; i < sgp_pkg::MAX_PARTS; i++) begin
                r_hits[i]  <= '0;
                r_sizes[i] <= '0;
            end
        end else begin
            if (r_state == sgp_pkg::S_CLEAR) r_clr <= r_clr + 1'b1;
            r_p1_valid <= s_acc;
            if (r_out_valid && i_m_tready) r_out_valid <= 1'b0;
            if (hit_inc && (hit_rd != sgp_pkg::HIT_MAX)) begin
                r_hits[hit_addr] <= hit_rd + 1'b1;
            end
            unique case (r_state)
                sgp_pkg::S_LOOK: begin
                    r_idx   <= '0;
                    r_found <= 1'b0;
                    r_best  <= '0;
                end
                sgp_pkg::S_CHECK: begin
                    if (size_rd > r_capacity && !last_idx) r_idx <= r_idx + 1'b1;
                end
                sgp_pkg::S_SCORE: begin
                    if (!r_found || score > r_best_score) begin
                        r_found <= 1'b1;
                        r_best  <= r_idx;
                    end
                    if (!last_idx) r_idx <= r_idx + 1'b1;
                end
                sgp_pkg::S_WRITE: begin
                    if (out_free) begin
                        if (size_rd != sgp_pkg::SIZE_MAX) r_sizes[r_best] <= size_rd + 1'b1;
                        for (int i = 0; i < sgp_pkg::MAX_PARTS; i++) r_hits[i] <= '0;
                        r_out_valid <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_p1_nv <= i_s_tuser;
            r_vid   <= i_s_tdata[15:0];
        end
        if (r_state == sgp_pkg::S_MULA) begin
            r_pa <= sgp_pkg::PROD_W'(size_rd) * sgp_pkg::PROD_W'(sq_root);
        end
        if (r_state == sgp_pkg::S_MULB) begin
            r_pb <= sgp_pkg::PROD_W'({1'b0, size_rd} + 1'b1) * sgp_pkg::PROD_W'(sq_root);
        end
        if (r_state == sgp_pkg::S_DIFF) r_diff <= sgp_pkg::DIFF_W'(r_pb - r_pa);
        if (r_state == sgp_pkg::S_PEN)  r_pen <= pen_full[sgp_pkg::ALPHA_W+sgp_pkg::DIFF_W-1:16];
        if (r_state == sgp_pkg::S_SCORE && (!r_found || score > r_best_score)) begin
            r_best_score <= score;
        end
        if (r_state == sgp_pkg::S_WRITE && out_free) begin
            r_out_data <= {3'd0, r_found, r_best, r_vid};
        end
    end

`ifndef ASSERT_OFF
    a_clear_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sgp_pkg::S_CLEAR) |-> !o_s_tready)
        else $error("item accepted during table clear");
    a_root_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sq_done |-> (r_state == sgp_pkg::S_ROOTA || r_state == sgp_pkg::S_ROOTB))
        else $error("square root finished outside a root state");
    a_best_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sgp_pkg::S_WRITE) |-> ({1'b0, r_best} < parts))
        else $error("chosen part beyond active part count");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_tready) |=> $stable(r_out_data))
        else $error("pending result overwritten");
`endif

endmodule

// ===== rtl/core/sgp_ram.sv =====
// Generic single-port RAM with registered read.
module sgp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule

// ===== rtl/core/sgp_isqrt.sv =====
// Iterative integer square root of n << 32, two radicand bits per cycle.
module sgp_isqrt (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [sgp_pkg::N_W-1:0]   i_n,
    output logic                      o_done,
    output logic [sgp_pkg::ROOT_W-1:0] o_root
);

    localparam int X_W   = 2 * sgp_pkg::ROOT_W;
    localparam int REM_W = sgp_pkg::ROOT_W + 3;
    localparam int CNT_W = $clog2(sgp_pkg::ROOT_W + 1);

    logic [X_W-1:0]   r_x;
    logic [REM_W-1:0] r_rem;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    logic             take;

    assign rem_sh = {r_rem[REM_W-3:0], r_x[X_W-1 -: 2]};
    assign trial  = {1'b0, o_root, 2'b01};
    assign take   = rem_sh >= trial;
    assign o_done = r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(sgp_pkg::ROOT_W - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= {{(X_W - sgp_pkg::N_W - 32){1'b0}}, i_n, 32'd0};
            r_rem  <= '0;
            o_root <= '0;
        end else if (r_busy) begin
            r_x    <= {r_x[X_W-3:0], 2'b00};
            r_rem  <= take ? rem_sh - trial : rem_sh;
            o_root <= {o_root[sgp_pkg::ROOT_W-2:0], take};
        end
    end

endmodule
